// File: design/circular_list_append_delete_core_macros.svh
// Assertion macros shared by the list core.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef CIRCULAR_LIST_APPEND_DELETE_CORE_MACROS_SVH
`define CIRCULAR_LIST_APPEND_DELETE_CORE_MACROS_SVH

// The condition must hold at every clock edge.
`define CLAD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define CLAD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define CLAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/clad_pkg.sv
package clad_pkg;

  // Default number of node slots.
  localparam int unsigned CAPACITY_DEF = 16;

  // Width of the index and count result fields.
  localparam int unsigned IDX_W = 7;

  // Operation codes of an input item.
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_DUMP   = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  // One input item.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [7:0]         position;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item_value;
    logic [IDX_W-1:0]   item_index;
    logic [IDX_W-1:0]   count;
    logic               last_of_run;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_app;
    logic start_del;
    logic start_dump;
    logic emit_full;
    logic emit_invalid;
    logic emit_empty;
    logic app_link;
    logic app_tail;
    logic walk_step;
    logic del_finish;
    logic dump_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_bad;
    logic walk_hit;
    logic dump_last;
  } sts_t;

endpackage

// File: design/clad_ctrl.sv
module clad_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic [1:0]      kind_i,
  input  clad_pkg::sts_t  sts_i,
  output clad_pkg::cmd_t  cmd_o,
  output logic            busy_o
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_APP_LINK = 3'd1;
  localparam logic [2:0] S_APP_TAIL = 3'd2;
  localparam logic [2:0] S_DEL_WALK = 3'd3;
  localparam logic [2:0] S_DUMP     = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (kind_i)
            clad_pkg::KIND_APPEND: begin
              if (sts_i.full) begin
                cmd_o.emit_full = 1'b1;
              end else begin
                cmd_o.start_app = 1'b1;
                state_d = S_APP_LINK;
              end
            end
            clad_pkg::KIND_DELETE: begin
              if (sts_i.pos_bad) begin
                cmd_o.emit_invalid = 1'b1;
              end else begin
                cmd_o.start_del = 1'b1;
                state_d = S_DEL_WALK;
              end
            end
            clad_pkg::KIND_DUMP: begin
              if (sts_i.empty) begin
                cmd_o.emit_empty = 1'b1;
              end else begin
                cmd_o.start_dump = 1'b1;
                state_d = S_DUMP;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_APP_LINK: begin
        cmd_o.app_link = 1'b1;
        state_d = S_APP_TAIL;
      end
      S_APP_TAIL: begin
        cmd_o.app_tail = 1'b1;
        state_d = S_IDLE;
      end
      S_DEL_WALK: begin
        if (sts_i.walk_hit) begin
          cmd_o.del_finish = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_DUMP: begin
        cmd_o.dump_step = 1'b1;
        if (sts_i.dump_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// File: design/clad_dp.sv
`include "circular_list_append_delete_core_macros.svh"

module clad_dp #(
  parameter int unsigned CAPACITY = clad_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  clad_pkg::in_item_t  item_i,
  input  clad_pkg::cmd_t      cmd_i,
  output clad_pkg::sts_t      sts_o,
  output logic                result_valid_o,
  output clad_pkg::out_item_t result_o
);

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = clad_pkg::IDX_W;

  // Slot memories and the stack of released slots.
  logic signed [31:0] val_mem  [CAPACITY];
  logic [SW-1:0]      next_mem [CAPACITY];
  logic [SW-1:0]      free_mem [CAPACITY];

  logic [SW-1:0]      head_q, tail_q, slot_q, prev_q, cur_q;
  logic [CW-1:0]      count_q, sp_q, fresh_q;
  logic [IW-1:0]      idx_q, pos_q;
  logic signed [31:0] val_q;
  logic signed [31:0] val_rd_q;
  logic [SW-1:0]      next_rd_q, free_rd_q;

  logic [SW-1:0]      rd_addr;
  logic [CW-1:0]      sp_dec;
  logic [SW-1:0]      new_slot;
  logic               nx_we;
  logic [SW-1:0]      nx_waddr, nx_wdata;

  logic                out_valid_q, out_valid_d;
  clad_pkg::out_item_t out_q, out_d;

  // Status toward the controller.
  assign sts_o.full      = (count_q == CW'(CAPACITY));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.pos_bad   = (item_i.position == 8'd0) ||
                           ({1'b0, item_i.position} > 9'(count_q));
  assign sts_o.walk_hit  = (idx_q == pos_q);
  assign sts_o.dump_last = (idx_q == IW'(count_q));

  // A released slot is reused first; otherwise the next never-used slot is taken.
  assign sp_dec   = sp_q - CW'(1);
  assign new_slot = (sp_q != '0) ? free_rd_q : fresh_q[SW-1:0];

  // Walk read address: the head to begin, then the link just read.
  always_comb begin
    if (cmd_i.start_del || cmd_i.start_dump) begin
      rd_addr = head_q;
    end else if (cmd_i.walk_step || cmd_i.dump_step) begin
      rd_addr = next_rd_q;
    end else begin
      rd_addr = cur_q;
    end
  end

  // Link memory write port.
  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = new_slot;
    nx_wdata = (count_q == '0) ? new_slot : head_q;
    if (cmd_i.app_link) begin
      nx_we = 1'b1;
    end else if (cmd_i.app_tail && (count_q != '0)) begin
      nx_we    = 1'b1;
      nx_waddr = tail_q;
      nx_wdata = slot_q;
    end else if (cmd_i.del_finish && (count_q != CW'(1))) begin
      nx_we    = 1'b1;
      nx_waddr = prev_q;
      nx_wdata = next_rd_q;
    end
  end

  // Memory ports with registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.app_link) begin
      val_mem[new_slot] <= val_q;
    end
    val_rd_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) begin
      next_mem[nx_waddr] <= nx_wdata;
    end
    next_rd_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.del_finish) begin
      free_mem[sp_q[SW-1:0]] <= cur_q;
    end
    free_rd_q <= free_mem[sp_dec[SW-1:0]];
  end

  // List bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      sp_q    <= '0;
      fresh_q <= '0;
    end else begin
      if (cmd_i.app_link) begin
        if (sp_q != '0) begin
          sp_q <= sp_dec;
        end else begin
          fresh_q <= fresh_q + CW'(1);
        end
      end
      if (cmd_i.app_tail) begin
        if (count_q == '0) begin
          head_q <= slot_q;
        end
        tail_q  <= slot_q;
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.del_finish) begin
        if (count_q == CW'(1)) begin
          head_q <= '0;
          tail_q <= '0;
        end else begin
          if (pos_q == IW'(1)) begin
            head_q <= next_rd_q;
          end
          if (pos_q == IW'(count_q)) begin
            tail_q <= prev_q;
          end
        end
        sp_q    <= sp_q + CW'(1);
        count_q <= count_q - CW'(1);
      end
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_app) begin
      val_q <= item_i.value;
    end
    if (cmd_i.app_link) begin
      slot_q <= new_slot;
    end
    if (cmd_i.start_del) begin
      pos_q  <= item_i.position[IW-1:0];
      prev_q <= tail_q;
      cur_q  <= head_q;
    end
    if (cmd_i.start_del || cmd_i.start_dump) begin
      idx_q <= IW'(1);
    end
    if (cmd_i.walk_step) begin
      prev_q <= cur_q;
      cur_q  <= next_rd_q;
    end
    if (cmd_i.walk_step || cmd_i.dump_step) begin
      idx_q <= idx_q + IW'(1);
    end
  end

  // Result item selection.
  always_comb begin
    out_valid_d       = 1'b1;
    out_d.status      = clad_pkg::ST_OK;
    out_d.item_value  = '0;
    out_d.item_index  = '0;
    out_d.count       = IW'(count_q);
    out_d.last_of_run = 1'b1;
    if (cmd_i.emit_full) begin
      out_d.status = clad_pkg::ST_FULL;
    end else if (cmd_i.emit_invalid) begin
      out_d.status = clad_pkg::ST_INVALID;
    end else if (cmd_i.emit_empty) begin
      out_d.status = clad_pkg::ST_EMPTY;
    end else if (cmd_i.app_tail) begin
      out_d.count = IW'(count_q) + IW'(1);
    end else if (cmd_i.del_finish) begin
      out_d.item_value = val_rd_q;
      out_d.item_index = pos_q;
      out_d.count      = IW'(count_q) - IW'(1);
    end else if (cmd_i.dump_step) begin
      out_d.item_value  = val_rd_q;
      out_d.item_index  = idx_q;
      out_d.last_of_run = sts_o.dump_last;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // Output register: each result shows for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_d) begin
      out_q <= out_d;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  // The element count never passes the number of slots.
  `CLAD_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(CAPACITY), "count above capacity")
  // Every slot ever taken is in the list, on the release stack, or being linked in.
  `CLAD_ASSERT_ALWAYS(a_slot_accounting, fresh_q == count_q + sp_q + CW'(cmd_i.app_tail), "slots")
  // An empty list keeps both ends at slot zero.
  `CLAD_ASSERT_IMPL(a_empty_ends, count_q == '0, (head_q == '0) && (tail_q == '0), "ends not cleared")
  // A finished delete removes exactly one element.
  `CLAD_ASSERT_NEXT(a_del_count, cmd_i.del_finish, count_q == $past(count_q) - CW'(1), "delete count")

endmodule

// File: design/circular_list_append_delete_core.sv
// Circular singly linked list core: append, delete at position, dump.
// Results are registered; a rejected item is answered straight from idle, an append
// passes the link and tail states, a delete walks one link read per cycle to its position,
// and a dump emits one element per cycle; busy stays high until the last result.
// A new item is taken only in idle, once the previous item is through and busy is low.
// Reset empties the list at once; the slot memories need no clearing pass.
module circular_list_append_delete_core #(
  parameter int unsigned CAPACITY = clad_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  clad_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output clad_pkg::out_item_t result_o
);

  clad_pkg::cmd_t cmd;
  clad_pkg::sts_t sts;

  // Operation sequencing.
  clad_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .kind_i (item_i.kind),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // Slot memories, list pointers and the result register.
  clad_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// File: bench/tb_circular_list_append_delete_core.sv
module tb_circular_list_append_delete_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_CAP    = clad_pkg::CAPACITY_DEF;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RANDOM_ITEMS = 400;

  // Kind three is not an operation; the block must swallow it silently.
  localparam logic [1:0] KIND_SPARE = 2'd3;

  // Shape of one stretch of random traffic.
  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  clad_pkg::in_item_t  item_i = '0;
  logic                result_valid_o;
  clad_pkg::out_item_t result_o;

  // Predicted list contents, head first.
  logic signed [31:0] list_shadow[$];
  // Results predicted but not yet seen on the result ports.
  clad_pkg::out_item_t pending_reports[$];
  clad_pkg::out_item_t oldest_report;

  int  errors = 0;
  int  cycle_count = 0;
  bit  quiet_sender = 1'b0;

  circular_list_append_delete_core #(
    .CAPACITY(LIST_CAP)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Builds one result with the count the list holds at this point.
  function automatic clad_pkg::out_item_t make_report(logic [1:0] status,
                                                      logic signed [31:0] value,
                                                      int index, bit last);
    clad_pkg::out_item_t r;
    int n;
    n = list_shadow.size();
    r.status      = status;
    r.item_value  = value;
    r.item_index  = index[clad_pkg::IDX_W-1:0];
    r.count       = n[clad_pkg::IDX_W-1:0];
    r.last_of_run = last;
    return r;
  endfunction

  // Updates the shadow list for one accepted item and queues its results.
  function automatic void apply_list_op(clad_pkg::in_item_t it);
    int pos;
    logic signed [31:0] taken;
    case (it.kind)
      clad_pkg::KIND_APPEND: begin
        if (list_shadow.size() >= LIST_CAP) begin
          pending_reports.push_back(make_report(clad_pkg::ST_FULL, 0, 0, 1'b1));
        end else begin
          list_shadow.push_back(it.value);
          pending_reports.push_back(make_report(clad_pkg::ST_OK, 0, 0, 1'b1));
        end
      end
      clad_pkg::KIND_DELETE: begin
        pos = it.position;
        if (pos < 1 || pos > list_shadow.size()) begin
          pending_reports.push_back(make_report(clad_pkg::ST_INVALID, 0, 0, 1'b1));
        end else begin
          taken = list_shadow[pos-1];
          list_shadow.delete(pos-1);
          pending_reports.push_back(make_report(clad_pkg::ST_OK, taken, pos, 1'b1));
        end
      end
      clad_pkg::KIND_DUMP: begin
        if (list_shadow.size() == 0) begin
          pending_reports.push_back(make_report(clad_pkg::ST_EMPTY, 0, 0, 1'b1));
        end else begin
          foreach (list_shadow[i]) begin
            pending_reports.push_back(make_report(clad_pkg::ST_OK, list_shadow[i], i + 1,
                                                  i == list_shadow.size() - 1));
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Gap before the next item: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (quiet_sender) return 0;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Delete positions lean on the head and the tail, with some out of range.
  function automatic logic [7:0] pick_position();
    int r;
    int n;
    n = list_shadow.size();
    r = $urandom_range(99, 0);
    if (r < 28) return 8'd1;
    if (r < 48) return 8'(n);
    if (r < 78) return 8'($urandom_range(n, 1));
    if (r < 86) return 8'd0;
    if (r < 93) return 8'(n + 1);
    return 8'($urandom_range(255, 0));
  endfunction

  // Sends one item after a random gap and predicts it once the block is no longer busy.
  task automatic send_item(clad_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_i <= it;
    start  <= 1'b1;
    do @(posedge clk_i); while (busy);
    apply_list_op(it);
  endtask

  task automatic send_append(logic signed [31:0] value);
    clad_pkg::in_item_t it;
    it.kind     = clad_pkg::KIND_APPEND;
    it.value    = value;
    it.position = 8'($urandom());
    send_item(it);
  endtask

  task automatic send_delete(logic [7:0] position);
    clad_pkg::in_item_t it;
    it.kind     = clad_pkg::KIND_DELETE;
    it.value    = $urandom();
    it.position = position;
    send_item(it);
  endtask

  task automatic send_dump();
    clad_pkg::in_item_t it;
    it.kind     = clad_pkg::KIND_DUMP;
    it.value    = $urandom();
    it.position = 8'($urandom());
    send_item(it);
  endtask

  task automatic send_spare(logic signed [31:0] value, logic [7:0] position);
    clad_pkg::in_item_t it;
    it.kind     = KIND_SPARE;
    it.value    = value;
    it.position = position;
    send_item(it);
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Each result is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_reports.size() == 0) begin
        $error("result with nothing pending: status %0d value 0x%0h",
               result_o.status, result_o.item_value);
        errors++;
      end else begin
        oldest_report = pending_reports.pop_front();
        check_field("status", 32'(oldest_report.status), 32'(result_o.status));
        check_field("item_value", oldest_report.item_value, result_o.item_value);
        check_field("item_index", 32'(oldest_report.item_index), 32'(result_o.item_index));
        check_field("count", 32'(oldest_report.count), 32'(result_o.count));
        check_field("last_of_run", 32'(oldest_report.last_of_run),
                    32'(result_o.last_of_run));
      end
    end
  end

  // A dump and deletes on an empty list.
  task automatic test_empty_list();
    send_dump();
    send_delete(8'd1);
    send_delete(8'd0);
    send_delete(8'd255);
  endtask

  // Appends of extreme and mixed values, then a dump.
  task automatic test_append_extremes();
    send_append(32'sh8000_0000);
    send_append(32'sh7FFF_FFFF);
    send_append(32'sd0);
    send_append(-32'sd1);
    send_append(32'sh5A5A_A5A5);
    send_dump();
  endtask

  // Deletes at bad positions, the head, the tail, the middle and the lone node.
  task automatic test_delete_positions();
    send_delete(8'd0);
    send_delete(8'(list_shadow.size() + 1));
    send_delete(8'd255);
    send_delete(8'd1);
    send_delete(8'(list_shadow.size()));
    send_delete(8'd2);
    send_dump();
    send_delete(8'd1);
    send_delete(8'd1);
    send_dump();
  endtask

  // Kind three is ignored; the list must be untouched around it.
  task automatic test_spare_kind();
    send_spare(-32'sd1, 8'hFF);
    send_append(32'sd7);
    send_spare(32'sd0, 8'h00);
    send_dump();
  endtask

  // Fills the list to capacity, appends past it, then works both ends.
  task automatic test_full_list();
    while (list_shadow.size() < LIST_CAP) send_append($urandom());
    send_append($urandom());
    send_append($urandom());
    send_dump();
    send_delete(8'(LIST_CAP));
    send_delete(8'(LIST_CAP));
    send_delete(8'd1);
    send_append($urandom());
    send_dump();
  endtask

  // Random traffic in stretches that fill, drain or hold the list.
  task automatic test_random_mix(int n_items);
    int   sent;
    int   stretch_left;
    int   app_w;
    int   del_w;
    int   r;
    mix_t mode;
    sent = 0;
    stretch_left = 0;
    mode = MIX_EVEN;
    while (sent < n_items) begin
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(60, 20);
        mode = mix_t'($urandom_range(2, 0));
        quiet_sender = ($urandom_range(3, 0) == 0);
      end
      stretch_left--;
      case (mode)
        MIX_FILL: begin
          app_w = 72;
          del_w = 15;
        end
        MIX_DRAIN: begin
          app_w = 15;
          del_w = 72;
        end
        default: begin
          app_w = 42;
          del_w = 45;
        end
      endcase
      r = $urandom_range(99, 0);
      if (r < 3) begin
        send_spare($urandom(), 8'($urandom()));
      end else begin
        if (r < app_w) send_append($urandom());
        else if (r < app_w + del_w) send_delete(pick_position());
        else send_dump();
        sent++;
      end
    end
    quiet_sender = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_append_extremes();
    test_delete_positions();
    test_spare_kind();
    test_full_list();
    test_random_mix(RANDOM_ITEMS);

    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    // A stray result would show up within one full walk of the list.
    repeat (2 * LIST_CAP + 8) @(posedge clk_i);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
